[sv/ipv4_forward_lpm_arp_core_macros.svh]
// Assertion macros for the IPv4 forwarding core.
`ifndef IPV4_FORWARD_LPM_ARP_CORE_MACROS_SVH
`define IPV4_FORWARD_LPM_ARP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on clk, disabled in reset
`define IPV4_FWD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv4_fwd assertion failed");
// next-cycle implication
`define IPV4_FWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv4_fwd assertion failed");
`else
`define IPV4_FWD_ASSERT(label, ante, cons)
`define IPV4_FWD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/ipv4_fwd_pkg.sv]
// Shared types and constants of the IPv4 forwarding core.
`timescale 1ns / 1ps
package ipv4_fwd_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned TTL_W       = 8;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_FWD       = 2'd0,
    OP_ADD_ROUTE = 2'd1,
    OP_ADD_RES   = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FORWARDED = 3'd0,
    ST_EXPIRED   = 3'd1,
    ST_NO_ROUTE  = 3'd2,
    ST_MISS      = 3'd3,
    ST_FULL      = 3'd4,
    ST_ACCEPTED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUTE,
    BK_RESOLVE
  } bk_state_t;

  // classified command handed from the front end to the back end
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gw;
    logic [MAC_W-1:0]  mac;
    logic [TTL_W-1:0]  ttl_out;
    logic              expired;
  } cmd_t;

endpackage

[sv/ipv4_fwd_ifs.sv]
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
interface ipv4_fwd_in_if;
  import ipv4_fwd_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ADDR_W-1:0] dest_addr;
  logic [ADDR_W-1:0] prefix_mask;
  logic [ADDR_W-1:0] next_hop;
  logic [MAC_W-1:0]  mac_addr;
  logic [TTL_W-1:0]  ttl;

  modport source (
    output valid, mode, dest_addr, prefix_mask, next_hop, mac_addr, ttl,
    input  ready
  );
  modport sink (
    input  valid, mode, dest_addr, prefix_mask, next_hop, mac_addr, ttl,
    output ready
  );
endinterface

interface ipv4_fwd_out_if;
  import ipv4_fwd_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [IDX_W-1:0]  route_index;
  logic [ADDR_W-1:0] hop_addr;
  logic [MAC_W-1:0]  mac_out;
  logic [TTL_W-1:0]  ttl_out;

  modport source (
    output valid, status, route_index, hop_addr, mac_out, ttl_out,
    input  ready
  );
  modport sink (
    input  valid, status, route_index, hop_addr, mac_out, ttl_out,
    output ready
  );
endinterface

[sv/ipv4_fwd_front.sv]
// Front end: accepts request items, decodes the mode and precomputes the TTL.
`timescale 1ns / 1ps
module ipv4_fwd_front (
  input  logic               clk,
  input  logic               rst_n,
  ipv4_fwd_in_if.sink        in_ch,
  output logic               push_vld,
  output ipv4_fwd_pkg::cmd_t push_cmd,
  input  logic               push_rdy
);
  import ipv4_fwd_pkg::*;

  logic             vld_r, vld_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [TTL_W-1:0] ttl_dec;

  assign in_ch.ready = !vld_r || push_rdy;
  assign push_vld    = vld_r;
  assign push_cmd    = cmd_r;

  always_comb begin
    // a TTL of zero saturates instead of wrapping
    ttl_dec          = (in_ch.ttl == '0) ? '0 : in_ch.ttl - TTL_W'(1);
    cmd_nxt.op       = op_t'(in_ch.mode);
    cmd_nxt.dest     = in_ch.dest_addr;
    cmd_nxt.mask     = in_ch.prefix_mask;
    cmd_nxt.gw       = in_ch.next_hop;
    cmd_nxt.mac      = in_ch.mac_addr;
    cmd_nxt.ttl_out  = ttl_dec;
    cmd_nxt.expired  = (ttl_dec == '0);
    vld_nxt          = in_ch.ready ? in_ch.valid : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

[sv/ipv4_fwd_queue.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module ipv4_fwd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_vld,
  input  ipv4_fwd_pkg::cmd_t push_cmd,
  output logic               push_rdy,
  output logic               pop_vld,
  output ipv4_fwd_pkg::cmd_t pop_cmd,
  input  logic               pop_rdy
);
  import ipv4_fwd_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_rdy = (cnt_r != CW'(QUEUE_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_cmd  = slot_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/ipv4_fwd_back.sv]
// Back end: route and resolution tables, table scans and result register.
`timescale 1ns / 1ps
`include "ipv4_forward_lpm_arp_core_macros.svh"
module ipv4_fwd_back #(
  parameter int unsigned ROUTE_DEPTH   = 128,
  parameter int unsigned RESOLVE_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_vld,
  input  ipv4_fwd_pkg::cmd_t pop_cmd,
  output logic               pop_rdy,
  ipv4_fwd_out_if.source     out_ch
);
  import ipv4_fwd_pkg::*;

  localparam int unsigned RT_AW  = $clog2(ROUTE_DEPTH);
  localparam int unsigned RT_CW  = $clog2(ROUTE_DEPTH + 1);
  localparam int unsigned RS_AW  = $clog2(RESOLVE_DEPTH);
  localparam int unsigned RS_CW  = $clog2(RESOLVE_DEPTH + 1);
  localparam int unsigned SCAN_W = (RT_CW > RS_CW) ? RT_CW : RS_CW;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gw;
  } rt_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] ip;
    logic [MAC_W-1:0]  mac;
  } rs_entry_t;

  bk_state_t         state_r, state_nxt;
  logic [RT_CW-1:0]  rt_cnt_r, rt_cnt_nxt;
  logic [RS_CW-1:0]  rs_cnt_r, rs_cnt_nxt;

  rt_entry_t         rt_mem [ROUTE_DEPTH];
  rs_entry_t         rs_mem [RESOLVE_DEPTH];
  rt_entry_t         rt_q_r;
  rs_entry_t         rs_q_r;
  logic              rt_we, rt_re, rs_we, rs_re;

  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [RT_AW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [ADDR_W-1:0] dest_r, dest_nxt;
  logic [TTL_W-1:0]  ttl_r, ttl_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] best_mask_r, best_mask_nxt;
  logic [RT_AW-1:0]  best_idx_r, best_idx_nxt;
  logic [ADDR_W-1:0] best_gw_r, best_gw_nxt;
  logic [ADDR_W-1:0] hop_r, hop_nxt;

  logic              out_vld_r, out_vld_nxt;
  status_t           out_stat_r, out_stat_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [ADDR_W-1:0] out_hop_r, out_hop_nxt;
  logic [MAC_W-1:0]  out_mac_r, out_mac_nxt;
  logic [TTL_W-1:0]  out_ttl_r, out_ttl_nxt;

  logic out_free, pop;
  logic rt_issue, rt_hit, rt_done;
  logic rs_more, rs_issue, rs_hit, rs_end;

  assign out_free = !out_vld_r || out_ch.ready;
  assign pop_rdy  = (state_r == BK_IDLE) && out_free;
  assign pop      = pop_vld && pop_rdy;

  assign rt_issue = (state_r == BK_ROUTE) && (scan_r < SCAN_W'(rt_cnt_r));
  assign rt_hit   = (state_r == BK_ROUTE) && cmp_vld_r &&
                    ((dest_r & rt_q_r.mask) == rt_q_r.prefix) &&
                    (rt_q_r.mask >= best_mask_r);
  assign rt_done  = (state_r == BK_ROUTE) && !rt_issue && !cmp_vld_r;

  assign rs_more  = (scan_r < SCAN_W'(rs_cnt_r));
  assign rs_hit   = (state_r == BK_RESOLVE) && cmp_vld_r && (rs_q_r.ip == hop_r);
  assign rs_issue = (state_r == BK_RESOLVE) && !rs_hit && rs_more;
  assign rs_end   = (state_r == BK_RESOLVE) && !cmp_vld_r && !rs_more;

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_stat_r;
  assign out_ch.route_index = out_idx_r;
  assign out_ch.hop_addr    = out_hop_r;
  assign out_ch.mac_out     = out_mac_r;
  assign out_ch.ttl_out     = out_ttl_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop && (pop_cmd.op == OP_FWD) && !pop_cmd.expired) begin
          state_nxt = BK_ROUTE;
        end
      end
      BK_ROUTE: begin
        if (rt_done) begin
          state_nxt = found_r ? BK_RESOLVE : BK_IDLE;
        end
      end
      BK_RESOLVE: begin
        if (rs_hit || rs_end) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rt_cnt_nxt    = rt_cnt_r;
    rs_cnt_nxt    = rs_cnt_r;
    rt_we         = 1'b0;
    rt_re         = 1'b0;
    rs_we         = 1'b0;
    rs_re         = 1'b0;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    dest_nxt      = dest_r;
    ttl_nxt       = ttl_r;
    found_nxt     = found_r;
    best_mask_nxt = best_mask_r;
    best_idx_nxt  = best_idx_r;
    best_gw_nxt   = best_gw_r;
    hop_nxt       = hop_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_stat_nxt  = out_stat_r;
    out_idx_nxt   = out_idx_r;
    out_hop_nxt   = out_hop_r;
    out_mac_nxt   = out_mac_r;
    out_ttl_nxt   = out_ttl_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop) begin
          out_vld_nxt   = !((pop_cmd.op == OP_FWD) && !pop_cmd.expired);
          out_stat_nxt  = ST_ACCEPTED;
          out_idx_nxt   = '0;
          out_hop_nxt   = '0;
          out_mac_nxt   = '0;
          out_ttl_nxt   = '0;
          dest_nxt      = pop_cmd.dest;
          ttl_nxt       = pop_cmd.ttl_out;
          scan_nxt      = '0;
          cmp_vld_nxt   = 1'b0;
          found_nxt     = 1'b0;
          best_mask_nxt = '0;
          unique case (pop_cmd.op)
            OP_FWD: begin
              if (pop_cmd.expired) begin
                out_stat_nxt = ST_EXPIRED;
              end
            end
            OP_ADD_ROUTE: begin
              if (rt_cnt_r >= RT_CW'(ROUTE_DEPTH)) begin
                out_stat_nxt = ST_FULL;
              end else begin
                rt_we      = 1'b1;
                rt_cnt_nxt = rt_cnt_r + RT_CW'(1);
              end
            end
            OP_ADD_RES: begin
              if (rs_cnt_r >= RS_CW'(RESOLVE_DEPTH)) begin
                out_stat_nxt = ST_FULL;
              end else begin
                rs_we      = 1'b1;
                rs_cnt_nxt = rs_cnt_r + RS_CW'(1);
              end
            end
            OP_CLEAR: begin
              rt_cnt_nxt = '0;
              rs_cnt_nxt = '0;
            end
            default: out_stat_nxt = ST_ACCEPTED;
          endcase
        end
      end
      BK_ROUTE: begin
        rt_re       = rt_issue;
        cmp_vld_nxt = rt_issue;
        cmp_idx_nxt = scan_r[RT_AW-1:0];
        if (rt_issue) begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
        // >= lets a later route of equal mask take over
        if (rt_hit) begin
          found_nxt     = 1'b1;
          best_mask_nxt = rt_q_r.mask;
          best_idx_nxt  = cmp_idx_r;
          best_gw_nxt   = rt_q_r.gw;
        end
        if (rt_done) begin
          scan_nxt = '0;
          if (!found_r) begin
            out_vld_nxt  = 1'b1;
            out_stat_nxt = ST_NO_ROUTE;
            out_ttl_nxt  = ttl_r;
          end else begin
            hop_nxt = (best_gw_r == '0) ? dest_r : best_gw_r;
          end
        end
      end
      BK_RESOLVE: begin
        rs_re       = rs_issue;
        cmp_vld_nxt = rs_issue;
        if (rs_issue) begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
        if (rs_hit || rs_end) begin
          out_vld_nxt  = 1'b1;
          out_stat_nxt = rs_hit ? ST_FORWARDED : ST_MISS;
          out_idx_nxt  = IDX_W'(best_idx_r);
          out_hop_nxt  = hop_r;
          out_mac_nxt  = rs_hit ? rs_q_r.mac : '0;
          out_ttl_nxt  = ttl_r;
        end
      end
      default: out_vld_nxt = out_vld_r && !out_ch.ready;
    endcase
  end

  // table memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (rt_we) begin
      rt_mem[rt_cnt_r[RT_AW-1:0]] <= '{prefix: pop_cmd.dest, mask: pop_cmd.mask,
                                       gw: pop_cmd.gw};
    end
    if (rt_re) begin
      rt_q_r <= rt_mem[scan_r[RT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_cnt_r[RS_AW-1:0]] <= '{ip: pop_cmd.dest, mac: pop_cmd.mac};
    end
    if (rs_re) begin
      rs_q_r <= rs_mem[scan_r[RS_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      rt_cnt_r  <= '0;
      rs_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rt_cnt_r  <= rt_cnt_nxt;
      rs_cnt_r  <= rs_cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    scan_r      <= scan_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    dest_r      <= dest_nxt;
    ttl_r       <= ttl_nxt;
    found_r     <= found_nxt;
    best_mask_r <= best_mask_nxt;
    best_idx_r  <= best_idx_nxt;
    best_gw_r   <= best_gw_nxt;
    hop_r       <= hop_nxt;
    out_stat_r  <= out_stat_nxt;
    out_idx_r   <= out_idx_nxt;
    out_hop_r   <= out_hop_nxt;
    out_mac_r   <= out_mac_nxt;
    out_ttl_r   <= out_ttl_nxt;
  end

  // result register stays empty while a lookup is in flight
  `IPV4_FWD_ASSERT(a_scan_out_empty, state_r != BK_IDLE, !out_vld_r)
  `IPV4_FWD_ASSERT(a_resolve_has_route, state_r == BK_RESOLVE, found_r)
  `IPV4_FWD_ASSERT(a_rt_cnt_bound, 1'b1, rt_cnt_r <= RT_CW'(ROUTE_DEPTH))
  `IPV4_FWD_ASSERT(a_rs_cnt_bound, 1'b1, rs_cnt_r <= RS_CW'(RESOLVE_DEPTH))
  `IPV4_FWD_ASSERT_NEXT(a_hit_sets_found, rt_hit, found_r)

endmodule

[sv/ipv4_forward_lpm_arp_core.sv]
// Top level of the IPv4 forwarding core with route and resolution tables.
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    mode, dest_addr, prefix_mask, next_hop, mac_addr, ttl
//   out_ch    source     valid/ready    status, route_index, hop_addr, mac_out, ttl_out
//
// Add, clear and expired items pass the front register and the queue to the result register.
// Forward items scan the routes, then on a match the resolution entries; the single read
// port of the route memory and of the resolution memory each give one compare per cycle.
// Reset empties both tables through their counts; no clearing pass is needed.
// A front register and a 2-entry queue keep taking items while the back end scans
// or its result waits on out_ch.ready.
`timescale 1ns / 1ps
module ipv4_forward_lpm_arp_core #(
  parameter int unsigned ROUTE_DEPTH   = 128,
  parameter int unsigned RESOLVE_DEPTH = 128
) (
  input logic             clk,
  input logic             rst_n,
  ipv4_fwd_in_if.sink     in_ch,
  ipv4_fwd_out_if.source  out_ch
);
  import ipv4_fwd_pkg::*;

  logic push_vld, push_rdy;
  cmd_t push_cmd;
  logic pop_vld, pop_rdy;
  cmd_t pop_cmd;

  ipv4_fwd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push_vld (push_vld),
    .push_cmd (push_cmd),
    .push_rdy (push_rdy)
  );

  ipv4_fwd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (push_vld),
    .push_cmd (push_cmd),
    .push_rdy (push_rdy),
    .pop_vld  (pop_vld),
    .pop_cmd  (pop_cmd),
    .pop_rdy  (pop_rdy)
  );

  ipv4_fwd_back #(
    .ROUTE_DEPTH   (ROUTE_DEPTH),
    .RESOLVE_DEPTH (RESOLVE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .pop_vld (pop_vld),
    .pop_cmd (pop_cmd),
    .pop_rdy (pop_rdy),
    .out_ch  (out_ch)
  );

endmodule

[verif/testbench.sv]
// Self-checking bench for the IPv4 forwarding core: routes, resolution entries, forwards.
`timescale 1ns / 1ps
module testbench;
  import ipv4_fwd_pkg::*;

  localparam int ROUTES       = 128;
  localparam int ENTRIES      = 128;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_LEN    = 150;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    op_t               mode;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gw;
    logic [MAC_W-1:0]  mac;
    logic [TTL_W-1:0]  ttl;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  route_index;
    logic [ADDR_W-1:0] hop;
    logic [MAC_W-1:0]  mac;
    logic [TTL_W-1:0]  ttl_out;
  } verdict_t;

  logic clk;
  logic rst_n;

  ipv4_fwd_in_if  req_ch ();
  ipv4_fwd_out_if res_ch ();

  ipv4_forward_lpm_arp_core #(
    .ROUTE_DEPTH  (ROUTES),
    .RESOLVE_DEPTH(ENTRIES)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(res_ch)
  );

  // bench copy of the route and neighbor tables
  logic [ADDR_W-1:0] rt_net  [ROUTES];
  logic [ADDR_W-1:0] rt_mask [ROUTES];
  logic [ADDR_W-1:0] rt_gw   [ROUTES];
  int                rt_used = 0;
  logic [ADDR_W-1:0] nbr_ip  [ENTRIES];
  logic [MAC_W-1:0]  nbr_mac [ENTRIES];
  int                nbr_used = 0;

  request_t request_q[$];
  verdict_t expected_verdicts[$];
  request_t on_bus;
  int       n_accepted = 0;
  int       n_errors = 0;
  int       cycle_count = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  // generator pools used to aim forwards at installed routes and neighbors
  logic [ADDR_W-1:0] host_pool[$];
  logic [ADDR_W-1:0] net_pool[$];
  logic [ADDR_W-1:0] netmask_pool[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [MAC_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [ADDR_W-1:0] pick_host();
    if (host_pool.size() > 0 && $urandom_range(0, 99) < 80)
      return host_pool[$urandom_range(0, host_pool.size() - 1)];
    return $urandom;
  endfunction

  function automatic int sender_idle_pct();
    case ((n_accepted / PHASE_LEN) % 4)
      1: return 65;
      3: return 27;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((n_accepted / PHASE_LEN) % 4)
      2: return 65;
      3: return 27;
      default: return 0;
    endcase
  endfunction

  task automatic push_request(input op_t m, input logic [ADDR_W-1:0] d,
                              input logic [ADDR_W-1:0] mk, input logic [ADDR_W-1:0] g,
                              input logic [MAC_W-1:0] mc, input logic [TTL_W-1:0] t);
    request_t r;
    r.mode = m;
    r.dest = d;
    r.mask = mk;
    r.gw   = g;
    r.mac  = mc;
    r.ttl  = t;
    request_q.push_back(r);
  endtask

  // table update and forwarding decision for one accepted item
  task automatic compute_forwarding(input request_t r, output verdict_t v);
    logic [ADDR_W-1:0] best_mask;
    logic [ADDR_W-1:0] hop;
    logic [TTL_W-1:0]  ttl_dec;
    int                best;
    bit                found;
    v = '0;
    v.status = ST_ACCEPTED;
    case (r.mode)
      OP_ADD_ROUTE: begin
        if (rt_used >= ROUTES) begin
          v.status = ST_FULL;
        end else begin
          rt_net[rt_used]  = r.dest;
          rt_mask[rt_used] = r.mask;
          rt_gw[rt_used]   = r.gw;
          rt_used++;
        end
      end
      OP_ADD_RES: begin
        if (nbr_used >= ENTRIES) begin
          v.status = ST_FULL;
        end else begin
          nbr_ip[nbr_used]  = r.dest;
          nbr_mac[nbr_used] = r.mac;
          nbr_used++;
        end
      end
      OP_CLEAR: begin
        rt_used  = 0;
        nbr_used = 0;
      end
      default: begin
        ttl_dec = (r.ttl == '0) ? '0 : r.ttl - 1'b1;
        if (ttl_dec == '0) begin
          v.status = ST_EXPIRED;
        end else begin
          best_mask = '0;
          best = 0;
          found = 1'b0;
          v.ttl_out = ttl_dec;
          // >= so a later route of equal mask length takes over
          for (int i = 0; i < rt_used; i++) begin
            if ((r.dest & rt_mask[i]) == rt_net[i] && rt_mask[i] >= best_mask) begin
              best_mask = rt_mask[i];
              best = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            v.status = ST_NO_ROUTE;
          end else begin
            hop = (rt_gw[best] == '0) ? r.dest : rt_gw[best];
            v.route_index = best[IDX_W-1:0];
            v.hop = hop;
            v.status = ST_MISS;
            for (int j = 0; j < nbr_used; j++) begin
              if (nbr_ip[j] == hop) begin
                v.status = ST_FORWARDED;
                v.mac = nbr_mac[j];
                break;
              end
            end
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTED)
      $display("[%0t] MISMATCH %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string field, input logic [MAC_W-1:0] got,
                             input logic [MAC_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, expected %0h", field, got, want));
  endtask

  initial begin : stimulus
    int                episode;
    int                n;
    int                pick;
    int                len;
    int                n_directed;
    bit                full_fill;
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] msk;
    logic [ADDR_W-1:0] gw;
    rst_n = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = '0;
    req_ch.dest_addr   = '0;
    req_ch.prefix_mask = '0;
    req_ch.next_hop    = '0;
    req_ch.mac_addr    = '0;
    req_ch.ttl         = '0;
    res_ch.ready       = 1'b0;

    // empty tables, TTL boundary values
    push_request(OP_FWD, 32'h0A01_0203, '0, '0, '0, 8'd64);
    push_request(OP_FWD, 32'h0A01_0203, '0, '0, '0, 8'd0);
    push_request(OP_FWD, 32'h0A01_0203, '0, '0, '0, 8'd1);
    push_request(OP_FWD, 32'h0A01_0203, '0, '0, '0, 8'd2);
    // default route, direct /8, two equal /16s, host route of all ones
    push_request(OP_ADD_ROUTE, 32'h0, 32'h0, 32'hC0A8_0001, '0, '0);
    push_request(OP_ADD_ROUTE, 32'h0A00_0000, 32'hFF00_0000, 32'h0, '0, '0);
    push_request(OP_ADD_ROUTE, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, '0, '0);
    push_request(OP_ADD_ROUTE, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FD, '0, '0);
    push_request(OP_ADD_ROUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 48'hFFFF_FFFF_FFFF, 8'hFF);
    // duplicate neighbor address: first entry must win
    push_request(OP_ADD_RES, 32'h0A01_00FD, '0, '0, 48'hFFFF_FFFF_FFFF, '0);
    push_request(OP_ADD_RES, 32'h0A01_00FD, '0, '0, 48'h0000_0000_0001, '0);
    push_request(OP_ADD_RES, 32'h0A02_0304, '0, '0, 48'hAAAA_5555_AAAA, '0);
    push_request(OP_ADD_RES, 32'hFFFF_FFFF, '0, '0, 48'h0, '0);
    push_request(OP_FWD, 32'h0A01_0203, '0, '0, '0, 8'd255);
    push_request(OP_FWD, 32'h0A02_0304, '0, '0, '0, 8'd100);
    push_request(OP_FWD, 32'h0A03_0000, '0, '0, '0, 8'd2);
    push_request(OP_FWD, 32'hC000_0201, '0, '0, '0, 8'd33);
    push_request(OP_FWD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 48'hFFFF_FFFF_FFFF, 8'd255);
    // non-contiguous mask beats the default route
    push_request(OP_ADD_ROUTE, 32'h00FF_00FF, 32'h00FF_00FF, 32'h0102_0304, '0, '0);
    push_request(OP_FWD, 32'h12FF_34FF, '0, '0, '0, 8'd10);
    push_request(OP_FWD, 32'h0, '0, '0, '0, 8'd0);
    push_request(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 48'hFFFF_FFFF_FFFF, 8'hFF);
    push_request(OP_FWD, 32'h0A01_0203, '0, '0, '0, 8'd64);
    // zero mask with a nonzero prefix never matches
    push_request(OP_ADD_ROUTE, 32'h0100_0000, 32'h0, 32'h0, '0, '0);
    push_request(OP_FWD, 32'h0100_0000, '0, '0, '0, 8'd64);
    n_directed = request_q.size();

    episode = 0;
    while (request_q.size() < n_directed + RANDOM_ITEMS) begin
      full_fill = (episode == 3 || episode == 17);
      if (full_fill || $urandom_range(0, 99) < 85) begin
        push_request(OP_CLEAR, $urandom, $urandom, $urandom, rand48(), 8'($urandom));
        host_pool.delete();
        net_pool.delete();
        netmask_pool.delete();
      end
      // routes; a full fill runs past capacity
      n = full_fill ? ROUTES + 3 : $urandom_range(1, 12);
      repeat (n) begin
        if (net_pool.size() > 0 && $urandom_range(0, 99) < 15) begin
          pick = $urandom_range(0, net_pool.size() - 1);
          net = net_pool[pick];
          msk = netmask_pool[pick];
        end else begin
          len = $urandom_range(0, 32);
          if ($urandom_range(0, 99) < 20)
            msk = $urandom;
          else
            msk = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
          net = ($urandom_range(0, 99) < 90) ? ($urandom & msk) : $urandom;
        end
        gw = ($urandom_range(0, 99) < 35) ? 32'h0 : 32'($urandom);
        push_request(OP_ADD_ROUTE, net, msk, gw, rand48(), 8'($urandom));
        net_pool.push_back(net);
        netmask_pool.push_back(msk);
        host_pool.push_back(net | ($urandom & ~msk));
        if (gw != '0)
          host_pool.push_back(gw);
      end
      n = full_fill ? ENTRIES + 3 : $urandom_range(0, 10);
      repeat (n)
        push_request(OP_ADD_RES, pick_host(), $urandom, $urandom, rand48(), 8'($urandom));
      n = full_fill ? 25 : $urandom_range(4, 20);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 5)
          push_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                       rand48(), 8'($urandom));
        else if (pick < 10)
          push_request(OP_ADD_RES, pick_host(), $urandom, $urandom, rand48(),
                       8'($urandom));
        else if (pick < 20)
          push_request(OP_FWD, pick_host(), $urandom, $urandom, rand48(),
                       8'($urandom_range(0, 2)));
        else
          push_request(OP_FWD, pick_host(), $urandom, $urandom, rand48(),
                       8'($urandom));
      end
      episode++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin : drive_requests
    verdict_t v;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        compute_forwarding(on_bus, v);
        expected_verdicts.push_back(v);
        n_accepted <= n_accepted + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (request_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          on_bus = request_q.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.mode        <= on_bus.mode;
          req_ch.dest_addr   <= on_bus.dest;
          req_ch.prefix_mask <= on_bus.mask;
          req_ch.next_hop    <= on_bus.gw;
          req_ch.mac_addr    <= on_bus.mac;
          req_ch.ttl         <= on_bus.ttl;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result-side backpressure, with one long hold-off to fill the internal queue
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
      end
    end
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no item outstanding, status %0d",
                                  res_ch.status));
      end else begin
        want = expected_verdicts.pop_front();
        check_field("status", res_ch.status, want.status);
        check_field("route_index", res_ch.route_index, want.route_index);
        check_field("hop_addr", res_ch.hop_addr, want.hop);
        check_field("mac_out", res_ch.mac_out, want.mac);
        check_field("ttl_out", res_ch.ttl_out, want.ttl_out);
      end
    end
  end

  initial begin : end_of_run
    wait (rst_n === 1'b1);
    @(posedge clk);
    while (request_q.size() > 0 || req_ch.valid) @(posedge clk);
    while (expected_verdicts.size() > 0) @(posedge clk);
    // a late or extra result shows up in the checker during this window
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout, %0d results still outstanding", $time,
             expected_verdicts.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/ipv4_fwd_pkg.sv
sv/ipv4_fwd_ifs.sv
sv/ipv4_fwd_front.sv
sv/ipv4_fwd_queue.sv
sv/ipv4_fwd_back.sv
sv/ipv4_forward_lpm_arp_core.sv
verif/testbench.sv
